// ===== src/assert_macros.svh =====
// assertion macros shared by the envelope rtl
// no dependencies; modules that check themselves include this file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/adsr_pkg.sv =====
// shared constants, codes and bundle types of the adsr volume envelope
// no dependencies
package adsr_pkg;

  localparam int FRACTION_BITS = 10;
  localparam int VOICE_COUNT   = 16;

  localparam int LEVEL_W    = 16;
  localparam int VOICE_W    = 4;
  localparam int FREQ_W     = 16;
  localparam int PEAK_W     = 6;
  localparam int WAVE_W     = 2;
  localparam int PW_W       = 6;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int REG_IDX_W  = 2;
  localparam int DIVISOR_W  = CFG_W + 1;
  localparam int DIV_CNT_W  = $clog2(LEVEL_W);

  localparam int IN_FIELDS_W = VOICE_W + FREQ_W + PEAK_W + WAVE_W + PW_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VOICE_W + BYTE_W + 7) / 8) * 8;

  // input item kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // voice register indexes
  localparam logic [REG_IDX_W-1:0] REG_FREQ_LO = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FREQ_HI = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_VOLUME  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WAVE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DECAY   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE = 2'd3;

  localparam logic [CFG_W-1:0] ATTACK_RESET  = 8'd0;
  localparam logic [CFG_W-1:0] DECAY_RESET   = 8'd10;
  localparam logic [CFG_W-1:0] SUSTAIN_RESET = 8'd0;
  localparam logic [CFG_W-1:0] RELEASE_RESET = 8'd10;

  typedef struct packed {
    logic [CFG_W-1:0] attack;
    logic [CFG_W-1:0] decay;
    logic [CFG_W-1:0] sustain;
    logic [CFG_W-1:0] release_len;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [LEVEL_W-1:0]   dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== src/adsr_div.sv =====
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on adsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module adsr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  adsr_pkg::div_req_t req,
  output adsr_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [adsr_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [adsr_pkg::DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [adsr_pkg::DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [adsr_pkg::LEVEL_W-1:0]   quot_r, quot_nxt;

  logic [adsr_pkg::DIVISOR_W:0] trial;
  logic [adsr_pkg::DIVISOR_W:0] diff;
  logic                         fits;

  // remainder stays below the divisor, so the shifted trial fits back after subtract
  assign trial = {rem_r, quot_r[adsr_pkg::LEVEL_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = adsr_pkg::DIV_CNT_W'(adsr_pkg::LEVEL_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quot_nxt = req.dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[adsr_pkg::DIVISOR_W-1:0] : trial[adsr_pkg::DIVISOR_W-1:0];
      quot_nxt = {quot_r[adsr_pkg::LEVEL_W-2:0], fits};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  `ASSERT_CLK(a_div_latency, req.start && !busy_r |-> ##(adsr_pkg::LEVEL_W + 1) done_r, "divider did not finish on time")
  `ASSERT_NEVER(a_done_while_busy, done_r && busy_r, "divider done while still iterating")

endmodule

// ===== src/adsr_seq.sv =====
// envelope sequencer: phase state, level arithmetic and the result register
// depends on adsr_pkg and assert_macros.svh, drives the shared divider
`include "assert_macros.svh"

module adsr_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  adsr_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [adsr_pkg::VOICE_W-1:0]      in_voice,
  input  logic [adsr_pkg::FREQ_W-1:0]       in_freq,
  input  logic [adsr_pkg::PEAK_W-1:0]       in_peak,
  input  logic [adsr_pkg::WAVE_W-1:0]       in_wave,
  input  logic [adsr_pkg::PW_W-1:0]         in_pw,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [adsr_pkg::VOICE_W-1:0]      out_voice,
  output logic [adsr_pkg::REG_IDX_W-1:0]    out_reg,
  output logic [adsr_pkg::BYTE_W-1:0]       out_data,
  output logic                              out_last,
  output adsr_pkg::div_req_t                div_req,
  input  adsr_pkg::div_rsp_t                div_rsp
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;
  typedef enum logic [1:0] {ACT_START, ACT_DECAY, ACT_RELEASE} act_t;

  localparam logic [2:0] EMIT_FIRST = 3'd0;
  localparam logic [2:0] EMIT_VOL   = 3'd4;
  localparam logic [adsr_pkg::VOICE_W:0] VOICE_LIMIT =
    (adsr_pkg::VOICE_W + 1)'(adsr_pkg::VOICE_COUNT);
  localparam int LW = adsr_pkg::LEVEL_W;
  localparam int SW = adsr_pkg::CFG_W;

  state_t                        state_r, state_nxt;
  phase_t                        phase_r, phase_nxt;
  act_t                          act_r, act_nxt;
  logic [SW-1:0]                 steps_r, steps_nxt;
  logic [LW-1:0]                 level_r, level_nxt;
  logic [LW-1:0]                 step_r, step_nxt;
  logic [LW-1:0]                 half_r, half_nxt;
  logic [adsr_pkg::VOICE_W-1:0]  voice_r, voice_nxt;
  logic [adsr_pkg::FREQ_W-1:0]   freq_r, freq_nxt;
  logic [adsr_pkg::WAVE_W-1:0]   wave_r, wave_nxt;
  logic [adsr_pkg::PW_W-1:0]     pw_r, pw_nxt;
  logic [2:0]                    idx_r, idx_nxt;
  adsr_pkg::div_req_t            div_req_r, div_req_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [adsr_pkg::REG_IDX_W-1:0] out_reg_r, out_reg_nxt;
  logic [adsr_pkg::BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [adsr_pkg::VOICE_W-1:0]  out_voice_r, out_voice_nxt;

  logic [LW:0]                   sum;
  logic [LW-1:0]                 level_sat;
  logic [LW-1:0]                 lowered;
  logic [LW-1:0]                 lowered_q;
  logic [LW-1:0]                 peak_ext;
  logic [SW-1:0]                 steps_dec;
  logic [adsr_pkg::BYTE_W-1:0]   vol_byte;
  logic [adsr_pkg::REG_IDX_W-1:0] item_reg;
  logic [adsr_pkg::BYTE_W-1:0]   item_data;

  assign sum       = {1'b0, level_r} + {1'b0, step_r};
  assign level_sat = sum[LW] ? {LW{1'b1}} : sum[LW-1:0];
  assign lowered   = (level_r > step_r) ? (level_r - step_r) : '0;
  assign lowered_q = (level_r > div_rsp.quot) ? (level_r - div_rsp.quot) : '0;
  assign peak_ext  = LW'(in_peak);
  assign steps_dec = (steps_r != '0) ? (steps_r - 1'b1) : '0;
  // volume command byte: tag in the top two bits, integer part of the level below
  assign vol_byte  = {2'b11, level_r[adsr_pkg::FRACTION_BITS +: 6]};

  always_comb begin
    case (idx_r)
      3'd0: begin
        item_reg  = adsr_pkg::REG_FREQ_LO;
        item_data = freq_r[7:0];
      end
      3'd1: begin
        item_reg  = adsr_pkg::REG_FREQ_HI;
        item_data = freq_r[15:8];
      end
      3'd2: begin
        item_reg  = adsr_pkg::REG_VOLUME;
        item_data = {2'b11, 6'd0};
      end
      3'd3: begin
        item_reg  = adsr_pkg::REG_WAVE;
        item_data = {wave_r, pw_r};
      end
      default: begin
        item_reg  = adsr_pkg::REG_VOLUME;
        item_data = vol_byte;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    act_nxt       = act_r;
    steps_nxt     = steps_r;
    level_nxt     = level_r;
    step_nxt      = step_r;
    half_nxt      = half_r;
    voice_nxt     = voice_r;
    freq_nxt      = freq_r;
    wave_nxt      = wave_r;
    pw_nxt        = pw_r;
    idx_nxt       = idx_r;
    div_req_nxt   = div_req_r;
    div_req_nxt.start = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_reg_nxt   = out_reg_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_voice_nxt = out_voice_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == adsr_pkg::OP_START) begin
            if ({1'b0, in_voice} < VOICE_LIMIT) begin
              voice_nxt            = in_voice;
              freq_nxt             = in_freq;
              wave_nxt             = in_wave;
              pw_nxt               = in_pw;
              half_nxt             = peak_ext << (adsr_pkg::FRACTION_BITS - 1);
              div_req_nxt.start    = 1'b1;
              div_req_nxt.dividend = peak_ext << adsr_pkg::FRACTION_BITS;
              div_req_nxt.divisor  = {1'b0, cfg.attack} + 1'b1;
              act_nxt              = ACT_START;
              state_nxt            = S_DIV;
            end
          end else begin
            case (phase_r)
              PH_ATTACK: begin
                if (steps_r != '0) begin
                  steps_nxt = steps_r - 1'b1;
                  level_nxt = level_sat;
                  idx_nxt   = EMIT_VOL;
                  state_nxt = S_EMIT;
                end else begin
                  div_req_nxt.start    = 1'b1;
                  div_req_nxt.dividend = half_r;
                  div_req_nxt.divisor  = {1'b0, cfg.decay} + 1'b1;
                  act_nxt              = ACT_DECAY;
                  state_nxt            = S_DIV;
                end
              end
              PH_DECAY: begin
                if (steps_r != '0) begin
                  steps_nxt = steps_r - 1'b1;
                  level_nxt = lowered;
                  idx_nxt   = EMIT_VOL;
                  state_nxt = S_EMIT;
                end else if (cfg.sustain != '0) begin
                  phase_nxt = PH_SUSTAIN;
                  steps_nxt = cfg.sustain - 1'b1;
                end else begin
                  div_req_nxt.start    = 1'b1;
                  div_req_nxt.dividend = half_r;
                  div_req_nxt.divisor  = {1'b0, cfg.release_len} + 1'b1;
                  act_nxt              = ACT_RELEASE;
                  state_nxt            = S_DIV;
                end
              end
              PH_SUSTAIN: begin
                if (steps_r != '0) begin
                  steps_nxt = steps_r - 1'b1;
                end else begin
                  div_req_nxt.start    = 1'b1;
                  div_req_nxt.dividend = half_r;
                  div_req_nxt.divisor  = {1'b0, cfg.release_len} + 1'b1;
                  act_nxt              = ACT_RELEASE;
                  state_nxt            = S_DIV;
                end
              end
              PH_RELEASE: begin
                steps_nxt = steps_dec;
                if (steps_dec == '0) begin
                  level_nxt = '0;
                  phase_nxt = PH_IDLE;
                end else begin
                  level_nxt = lowered;
                end
                idx_nxt   = EMIT_VOL;
                state_nxt = S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          step_nxt  = div_rsp.quot;
          state_nxt = S_EMIT;
          idx_nxt   = EMIT_VOL;
          case (act_r)
            ACT_START: begin
              level_nxt = div_rsp.quot;
              steps_nxt = cfg.attack;
              phase_nxt = PH_ATTACK;
              idx_nxt   = EMIT_FIRST;
            end
            ACT_DECAY: begin
              level_nxt = lowered_q;
              steps_nxt = cfg.decay;
              phase_nxt = PH_DECAY;
            end
            ACT_RELEASE: begin
              steps_nxt = cfg.release_len;
              if (cfg.release_len == '0) begin
                level_nxt = '0;
                phase_nxt = PH_IDLE;
              end else begin
                level_nxt = lowered_q;
                phase_nxt = PH_RELEASE;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_voice_nxt = voice_r;
          out_reg_nxt   = item_reg;
          out_data_nxt  = item_data;
          out_last_nxt  = (idx_r == EMIT_VOL);
          if (idx_r == EMIT_VOL) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      phase_r           <= PH_IDLE;
      act_r             <= ACT_START;
      steps_r           <= '0;
      level_r           <= '0;
      step_r            <= '0;
      half_r            <= '0;
      voice_r           <= '0;
      idx_r             <= EMIT_FIRST;
      div_req_r.start   <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      phase_r           <= phase_nxt;
      act_r             <= act_nxt;
      steps_r           <= steps_nxt;
      level_r           <= level_nxt;
      step_r            <= step_nxt;
      half_r            <= half_nxt;
      voice_r           <= voice_nxt;
      idx_r             <= idx_nxt;
      div_req_r.start   <= div_req_nxt.start;
      out_valid_r       <= out_valid_nxt;
    end
    freq_r             <= freq_nxt;
    wave_r             <= wave_nxt;
    pw_r               <= pw_nxt;
    div_req_r.dividend <= div_req_nxt.dividend;
    div_req_r.divisor  <= div_req_nxt.divisor;
    out_voice_r        <= out_voice_nxt;
    out_reg_r          <= out_reg_nxt;
    out_data_r         <= out_data_nxt;
    out_last_r         <= out_last_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign div_req   = div_req_r;
  assign out_valid = out_valid_r;
  assign out_voice = out_voice_r;
  assign out_reg   = out_reg_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  `ASSERT_CLK(a_done_in_div, div_rsp.done |-> state_r == S_DIV, "divider result outside wait state")
  `ASSERT_CLK(a_last_is_volume, out_valid_r && out_last_r |-> out_reg_r == adsr_pkg::REG_VOLUME, "final transfer is not a volume write")
  `ASSERT_CLK(a_idle_silent, phase_r == PH_IDLE |-> level_r == '0, "level nonzero with no note running")
  `ASSERT_NEVER(a_ready_while_dividing, in_ready && (div_rsp.busy || div_req_r.start), "input ready while divider works")

endmodule

// ===== src/adsr_volume_envelope.sv =====
// top level of the adsr volume envelope: configuration registers and stream packing
// depends on adsr_pkg, adsr_div and adsr_seq
//
// usage
//   in channel: in_tuser selects the item kind (start note or timer tick), in_tdata
//   carries the note fields. a start emits five register writes for the voice:
//   frequency low, frequency high, volume zero, wave, then the first attack volume.
//   a tick emits at most one volume write; sustain ticks and ticks with no note emit
//   nothing. out_tlast marks the final write caused by an input item.
//   cfg channel: one write per transfer, index 0 attack, 1 decay, 2 sustain,
//   3 release; always ready; the user must write it only while the block is idle,
//   as the block itself enforces no such rule.
// sequencing
//   a start or a phase-changing tick runs a 16-step serial divide on the shared
//   divider, and its first result enters the output register once the quotient is
//   back; a plain tick goes straight to the emit state and loads its result from
//   there. in_tready is low from the accepting transfer until the last result sits
//   in the output register; the next item may be taken while that result waits.
// reset and stall: synchronous active-low reset returns the block to idle with
//   level zero and the default step counts; a stalled receiver holds the output
//   register and the sequencer waits, nothing is dropped
module adsr_volume_envelope (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // voice_sel, frequency, peak_volume, waveform, pulse_width, zero fill
  input  logic [adsr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op
  input  logic                               in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // voice_out, data, zero fill
  output logic [adsr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // reg_index
  output logic [adsr_pkg::REG_IDX_W-1:0]     out_tuser,
  output logic                               out_tlast,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adsr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [adsr_pkg::CFG_W-1:0]         cfg_data
);

  adsr_pkg::cfg_t     cfg_r, cfg_nxt;
  adsr_pkg::div_req_t div_req;
  adsr_pkg::div_rsp_t div_rsp;

  logic [adsr_pkg::VOICE_W-1:0] out_voice;
  logic [adsr_pkg::BYTE_W-1:0]  out_data;

  // field unpacking, lowest field first
  localparam int VS_LO = 0;
  localparam int FQ_LO = VS_LO + adsr_pkg::VOICE_W;
  localparam int PK_LO = FQ_LO + adsr_pkg::FREQ_W;
  localparam int WV_LO = PK_LO + adsr_pkg::PEAK_W;
  localparam int PW_LO = WV_LO + adsr_pkg::WAVE_W;

  // register file is always writable
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        adsr_pkg::CFG_ATTACK:  cfg_nxt.attack      = cfg_data;
        adsr_pkg::CFG_DECAY:   cfg_nxt.decay       = cfg_data;
        adsr_pkg::CFG_SUSTAIN: cfg_nxt.sustain     = cfg_data;
        adsr_pkg::CFG_RELEASE: cfg_nxt.release_len = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack      <= adsr_pkg::ATTACK_RESET;
      cfg_r.decay       <= adsr_pkg::DECAY_RESET;
      cfg_r.sustain     <= adsr_pkg::SUSTAIN_RESET;
      cfg_r.release_len <= adsr_pkg::RELEASE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // shared serial divider for the per-phase step sizes
  adsr_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // phase sequencer with the result register
  adsr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_voice  (in_tdata[VS_LO +: adsr_pkg::VOICE_W]),
    .in_freq   (in_tdata[FQ_LO +: adsr_pkg::FREQ_W]),
    .in_peak   (in_tdata[PK_LO +: adsr_pkg::PEAK_W]),
    .in_wave   (in_tdata[WV_LO +: adsr_pkg::WAVE_W]),
    .in_pw     (in_tdata[PW_LO +: adsr_pkg::PW_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_voice (out_voice),
    .out_reg   (out_tuser),
    .out_data  (out_data),
    .out_last  (out_tlast),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  // result packing: voice in the low nibble, register byte above, zero fill on top
  assign out_tdata = adsr_pkg::OUT_TDATA_W'({out_data, out_voice});

endmodule

// ===== sim/tb_adsr_volume_envelope.sv =====
// self-checking testbench for the adsr volume envelope: a queue-fed stream driver, a
// result monitor against a cycle-free envelope predictor, random stalls on both sides
// depends on adsr_pkg and adsr_volume_envelope
module tb_adsr_volume_envelope;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // receiver hold-off that backs the block up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  // settling time after the last expected write
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef logic [adsr_pkg::VOICE_W-1:0]   voice_t;
  typedef logic [adsr_pkg::FREQ_W-1:0]    freq_t;
  typedef logic [adsr_pkg::PEAK_W-1:0]    peak_t;
  typedef logic [adsr_pkg::WAVE_W-1:0]    wave_t;
  typedef logic [adsr_pkg::PW_W-1:0]      pw_t;
  typedef logic [adsr_pkg::REG_IDX_W-1:0] reg_idx_t;
  typedef logic [adsr_pkg::BYTE_W-1:0]    byte_t;
  typedef logic [adsr_pkg::CFG_W-1:0]     cfg_val_t;
  typedef logic [adsr_pkg::LEVEL_W-1:0]   level_t;

  // envelope phases as the predictor tracks them
  typedef enum logic [2:0] {
    ENV_IDLE, ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE
  } env_phase_t;

  // one input item: a start note or a timer tick
  typedef struct packed {
    logic   op;
    voice_t voice;
    freq_t  freq;
    peak_t  peak;
    wave_t  wave;
    pw_t    pw;
  } note_item_t;

  // one voice register write on the result side
  typedef struct packed {
    voice_t   voice;
    reg_idx_t reg_idx;
    byte_t    data;
    logic     last;
  } reg_write_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [adsr_pkg::IN_TDATA_W-1:0]     in_tdata = '0;
  logic                                in_tuser = adsr_pkg::OP_TICK;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [adsr_pkg::OUT_TDATA_W-1:0]    out_tdata;
  reg_idx_t                            out_tuser;
  logic                                out_tlast;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [adsr_pkg::CFG_ADDR_W-1:0]     cfg_addr = adsr_pkg::CFG_ATTACK;
  cfg_val_t                            cfg_data = '0;

  // items waiting to be offered, register writes still owed by the block
  note_item_t note_q[$];
  reg_write_t write_q[$];

  int unsigned mismatch_count = 0;
  bit          calm = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;  // ask the receiver for its long hold-off

  // predictor copy of the configuration and envelope state
  adsr_pkg::cfg_t env_cfg = '{attack: adsr_pkg::ATTACK_RESET,
                              decay: adsr_pkg::DECAY_RESET,
                              sustain: adsr_pkg::SUSTAIN_RESET,
                              release_len: adsr_pkg::RELEASE_RESET};
  env_phase_t     env_phase = ENV_IDLE;
  logic [8:0]     steps_left = '0;
  level_t         level = '0;
  level_t         level_step = '0;
  level_t         half_peak = '0;
  voice_t         active_voice = '0;

  adsr_volume_envelope uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // envelope predictor
  // ---------------------------------------------------------------------------

  // integer part of the level, six bits, with the volume register's fixed top bits
  function automatic byte_t volume_byte();
    return 8'hC0 | {2'b00, level[adsr_pkg::FRACTION_BITS +: 6]};
  endfunction

  // falling steps stop at zero
  task automatic lower_level();
    level = (level > level_step) ? level - level_step : '0;
  endtask

  task automatic owe_write(input voice_t voice, input reg_idx_t idx, input byte_t data,
                           input logic last);
    reg_write_t w;
    w = '{voice: voice, reg_idx: idx, data: data, last: last};
    write_q.push_back(w);
  endtask

  // first release write; a zero-length release drops straight to silence
  task automatic enter_release();
    level_step = half_peak / ({1'b0, env_cfg.release_len} + 9'd1);
    steps_left = {1'b0, env_cfg.release_len};
    if (env_cfg.release_len == '0) begin
      level = '0;
      env_phase = ENV_IDLE;
    end else begin
      env_phase = ENV_RELEASE;
      lower_level();
    end
    owe_write(active_voice, adsr_pkg::REG_VOLUME, volume_byte(), 1'b1);
  endtask

  // advance the envelope by one accepted item and queue the writes it owes
  task automatic advance_envelope(input note_item_t it);
    logic [adsr_pkg::LEVEL_W:0] sum;
    if (it.op == adsr_pkg::OP_START) begin
      if (int'(it.voice) >= adsr_pkg::VOICE_COUNT) return;
      active_voice = it.voice;
      half_peak = {10'd0, it.peak} << (adsr_pkg::FRACTION_BITS - 1);
      level_step = ({10'd0, it.peak} << adsr_pkg::FRACTION_BITS) /
                   ({1'b0, env_cfg.attack} + 9'd1);
      level = level_step;
      steps_left = {1'b0, env_cfg.attack};
      env_phase = ENV_ATTACK;
      owe_write(it.voice, adsr_pkg::REG_FREQ_LO, it.freq[7:0], 1'b0);
      owe_write(it.voice, adsr_pkg::REG_FREQ_HI, it.freq[15:8], 1'b0);
      owe_write(it.voice, adsr_pkg::REG_VOLUME, 8'hC0, 1'b0);
      owe_write(it.voice, adsr_pkg::REG_WAVE, {it.wave, it.pw}, 1'b0);
      owe_write(it.voice, adsr_pkg::REG_VOLUME, volume_byte(), 1'b1);
      return;
    end
    case (env_phase)
      ENV_ATTACK: begin
        if (steps_left > 0) begin
          steps_left = steps_left - 9'd1;
          sum = {1'b0, level} + {1'b0, level_step};
          level = sum[adsr_pkg::LEVEL_W] ? '1 : sum[adsr_pkg::LEVEL_W-1:0];
        end else begin
          level_step = half_peak / ({1'b0, env_cfg.decay} + 9'd1);
          steps_left = {1'b0, env_cfg.decay};
          env_phase = ENV_DECAY;
          lower_level();
        end
        owe_write(active_voice, adsr_pkg::REG_VOLUME, volume_byte(), 1'b1);
      end
      ENV_DECAY: begin
        if (steps_left > 0) begin
          steps_left = steps_left - 9'd1;
          lower_level();
          owe_write(active_voice, adsr_pkg::REG_VOLUME, volume_byte(), 1'b1);
        end else if (env_cfg.sustain != '0) begin
          // silent hold, first sustain tick already spent here
          env_phase = ENV_SUSTAIN;
          steps_left = {1'b0, env_cfg.sustain} - 9'd1;
        end else begin
          enter_release();
        end
      end
      ENV_SUSTAIN: begin
        if (steps_left > 0) steps_left = steps_left - 9'd1;
        else enter_release();
      end
      ENV_RELEASE: begin
        if (steps_left > 0) steps_left = steps_left - 9'd1;
        // last release write forces silence
        if (steps_left == 0) begin
          level = '0;
          env_phase = ENV_IDLE;
        end else begin
          lower_level();
        end
        owe_write(active_voice, adsr_pkg::REG_VOLUME, volume_byte(), 1'b1);
      end
      default: ;  // ticks with no note give nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_start(input voice_t voice, input freq_t freq, input peak_t peak,
                             input wave_t wave, input pw_t pw);
    note_item_t it;
    it = '{op: adsr_pkg::OP_START, voice: voice, freq: freq, peak: peak, wave: wave,
           pw: pw};
    note_q.push_back(it);
  endtask

  // start with the given peak and every other field random
  task automatic queue_start_rand(input peak_t peak);
    queue_start(voice_t'($urandom_range(0, 15)), freq_t'($urandom_range(0, 16'hFFFF)),
                peak, wave_t'($urandom_range(0, 3)), pw_t'($urandom_range(0, 63)));
  endtask

  // note fields ride along on ticks with random content; the block ignores them
  task automatic queue_tick();
    note_item_t it;
    it = '{op: adsr_pkg::OP_TICK, voice: voice_t'($urandom_range(0, 15)),
           freq: freq_t'($urandom_range(0, 16'hFFFF)), peak: peak_t'($urandom_range(0, 63)),
           wave: wave_t'($urandom_range(0, 3)), pw: pw_t'($urandom_range(0, 63))};
    note_q.push_back(it);
  endtask

  // whole notes with random content under the current setting; every fifth or so is
  // cut short by the next start, finished notes get a few ignored ticks after them
  task automatic queue_notes(input int unsigned count);
    int unsigned made;
    int unsigned span;
    int unsigned ticks;
    peak_t       peak;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 3) == 0) peak = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      else peak = peak_t'($urandom_range(0, 63));
      queue_start_rand(peak);
      // attack+1, decay+1, sustain, release ticks take the note back to idle
      span = env_cfg.attack + env_cfg.decay + env_cfg.sustain + env_cfg.release_len + 2;
      ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1) : span;
      repeat (ticks) queue_tick();
      made += 1 + ticks;
      if (ticks == span) repeat ($urandom_range(0, 3)) queue_tick();
    end
  endtask

  // one configuration transfer; the predictor takes the value at the same edge
  task automatic write_cfg(input logic [adsr_pkg::CFG_ADDR_W-1:0] addr, input cfg_val_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      adsr_pkg::CFG_ATTACK:  env_cfg.attack = value;
      adsr_pkg::CFG_DECAY:   env_cfg.decay = value;
      adsr_pkg::CFG_SUSTAIN: env_cfg.sustain = value;
      adsr_pkg::CFG_RELEASE: env_cfg.release_len = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_envelope(input cfg_val_t attack, input cfg_val_t decay,
                              input cfg_val_t sustain, input cfg_val_t rel);
    write_cfg(adsr_pkg::CFG_ATTACK, attack);
    write_cfg(adsr_pkg::CFG_DECAY, decay);
    write_cfg(adsr_pkg::CFG_SUSTAIN, sustain);
    write_cfg(adsr_pkg::CFG_RELEASE, rel);
    @(negedge clk);
  endtask

  // all items taken and all writes seen, then room for a silent sustain tick to finish
  task automatic drain();
    while (note_q.size() != 0 || write_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: offers the head of note_q, random gaps only between transfers
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) advance_envelope(note_q.pop_front());
      if (in_tvalid && !in_tready) begin
        // item still on offer, hold it
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (note_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 15);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tuser  <= note_q[0].op;
        in_tdata  <= {{(adsr_pkg::IN_TDATA_W - adsr_pkg::IN_FIELDS_W){1'b0}}, note_q[0].pw,
                      note_q[0].wave, note_q[0].peak, note_q[0].freq, note_q[0].voice};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: random stall bursts plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: each write against the oldest owed write, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    reg_write_t got;
    reg_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{voice: out_tdata[adsr_pkg::VOICE_W-1:0], reg_idx: out_tuser,
              data: out_tdata[adsr_pkg::VOICE_W +: adsr_pkg::BYTE_W], last: out_tlast};
      if (write_q.size() == 0) begin
        report_mismatch($sformatf("unexpected write voice %0d reg %0d data %02h last %0b",
                                  got.voice, got.reg_idx, got.data, got.last));
      end else begin
        want = write_q.pop_front();
        if (got.voice != want.voice)
          report_mismatch($sformatf("voice %0d, expected %0d", got.voice, want.voice));
        if (got.reg_idx != want.reg_idx)
          report_mismatch($sformatf("register %0d, expected %0d", got.reg_idx, want.reg_idx));
        if (got.data != want.data)
          report_mismatch($sformatf("data %02h, expected %02h", got.data, want.data));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any transfer on any channel counts as progress
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("** adsr_volume_envelope: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset setting: tick with no note, a silent minimal note, then a
    // restart on the top voice with every field at its maximum, run through to idle
    queue_tick();
    queue_start(4'd0, 16'h0000, 6'd0, 2'd0, 6'd0);
    queue_start(4'd15, 16'hFFFF, 6'd63, 2'd3, 6'd63);
    repeat (22) queue_tick();
    queue_tick();
    drain();

    // shortest envelope everywhere; the receiver holds off while items keep coming
    set_envelope(8'd0, 8'd0, 8'd0, 8'd0);
    queue_notes(90);
    hold_req = 1'b1;
    drain();

    // long attack leaves the peak short of its full value, so the release runs
    // into zero before its last write; a few sustain ticks in between
    set_envelope(8'd40, 8'd0, 8'd3, 8'd15);
    queue_start_rand(6'd1);
    repeat (40 + 1 + 1 + 3 + 15 + 2) queue_tick();
    drain();

    // largest step counts: each phase divides by 256 once, notes cut short
    set_envelope(8'd255, 8'd255, 8'd1, 8'd255);
    queue_start_rand(peak_t'($urandom_range(0, 63)));
    repeat (5) queue_tick();
    drain();
    set_envelope(8'd0, 8'd255, 8'd1, 8'd255);
    queue_start_rand(6'd63);
    repeat (5) queue_tick();
    drain();
    set_envelope(8'd0, 8'd0, 8'd0, 8'd255);
    queue_start_rand(6'd63);
    repeat (6) queue_tick();
    drain();

    // random short settings, the last one without idling
    for (int ph = 0; ph < 3; ph++) begin
      set_envelope(cfg_val_t'($urandom_range(0, 6)), cfg_val_t'($urandom_range(0, 6)),
                   cfg_val_t'($urandom_range(0, 6)), cfg_val_t'($urandom_range(0, 6)));
      if (ph == 2) calm = 1'b1;
      queue_notes(70);
      drain();
    end

    if (mismatch_count == 0) $display("** adsr_volume_envelope: PASSED **");
    else $display("** adsr_volume_envelope: FAILED **");
    $finish;
  end

endmodule

// ===== adsr_volume_envelope.f =====
+incdir+src
src/adsr_pkg.sv
src/adsr_div.sv
src/adsr_seq.sv
src/adsr_volume_envelope.sv
sim/tb_adsr_volume_envelope.sv
